>>> rtl/hsa_pkg.sv
// Package: shared constants, types and hash helpers for the sketch accumulator.
`default_nettype none
package hsa_pkg;
    localparam int WAYS        = 4;
    localparam int BUCKET_BITS = 3;
    localparam int BUCKETS     = 1 << BUCKET_BITS;
    localparam int SLOTS       = WAYS * BUCKETS;
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int WCNT_BITS   = $clog2(WAYS + 1);
    localparam int SCNT_BITS   = $clog2(SLOTS + 1);
    localparam int ENTRY_W     = 96;

    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd8 + 32'd1032032634;
    localparam logic [31:0] HASH_SEED2 = 32'd2818135537;

    localparam logic [1:0] KIND_EVICT = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic                 load_item;  // capture input item and seed the hash state
        logic                 hash_step;  // advance one mixing round
        logic                 rd_en;      // read slot at rd_addr
        logic [SLOT_BITS-1:0] rd_addr;
        logic                 track;      // fold read slot into victim search
        logic                 track_first;
        logic                 wr_en;      // write input item into slot
        logic                 wr_acc;     // write sum instead of item value
        logic [SLOT_BITS-1:0] wr_addr;
        logic                 out_load;   // load output register
        logic [1:0]           out_kind;   // evict, flush or end-marker kind
        logic                 out_last;
        logic                 out_victim; // take held victim instead of read data
        logic                 victim_save;// latch evicted entry before overwrite
    } hsa_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [BUCKET_BITS-1:0] bucket;
        logic                   hit;       // read slot matches item key
        logic [WAY_BITS-1:0]    victim_way;
        logic                   out_full;
    } hsa_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
        rotl = (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] v);
        mag = v[31] ? (32'd0 - v) : v;
    endfunction
endpackage
`default_nettype wire

>>> rtl/hsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module hsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/hsa_datapath.sv
// Datapath: hash rounds, slot memory, valid bits, victim search and output register.
`default_nettype none
module hsa_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [31:0]      in_row,
    input  wire logic [31:0]      in_col,
    input  wire logic [31:0]      in_value,
    input  wire hsa_pkg::hsa_cmd_t cmd,
    input  wire logic             valid_set,
    input  wire logic [hsa_pkg::SLOT_BITS-1:0] valid_addr,
    input  wire logic             valid_clear,
    output logic [hsa_pkg::SLOTS-1:0] valid_bits,
    output hsa_pkg::hsa_sts_t     sts,
    input  wire logic             out_take,
    output logic [1:0]            o_kind,
    output logic [31:0]           o_row,
    output logic [31:0]           o_col,
    output logic [31:0]           o_value,
    output logic                  o_last
);
    logic [31:0] row_reg, col_reg, val_reg;
    logic [31:0] ha_reg, hb_reg, hc_reg, ha_next, hb_next, hc_next;
    logic [2:0]  round_reg;
    logic [hsa_pkg::ENTRY_W-1:0] rd_data, wr_data;
    logic [hsa_pkg::SLOTS-1:0] valid_reg;
    logic [31:0] vmag_reg;
    logic [hsa_pkg::WAY_BITS-1:0] vway_reg, tway_reg;
    logic [hsa_pkg::ENTRY_W-1:0] victim_reg;
    logic        full_reg;
    logic [31:0] rmag;

    // Input capture and first six lookup3 final-mix steps, one round a cycle
    always_comb begin
        ha_next = ha_reg;
        hb_next = hb_reg;
        hc_next = hc_reg;
        case (round_reg)
            3'd0: hc_next = (hc_reg ^ hb_reg) - hsa_pkg::rotl(hb_reg, 14);
            3'd1: ha_next = (ha_reg ^ hc_reg) - hsa_pkg::rotl(hc_reg, 11);
            3'd2: hb_next = (hb_reg ^ ha_reg) - hsa_pkg::rotl(ha_reg, 25);
            3'd3: hc_next = (hc_reg ^ hb_reg) - hsa_pkg::rotl(hb_reg, 16);
            3'd4: ha_next = (ha_reg ^ hc_reg) - hsa_pkg::rotl(hc_reg, 4);
            3'd5: hb_next = (hb_reg ^ ha_reg) - hsa_pkg::rotl(ha_reg, 14);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            row_reg   <= in_row;
            col_reg   <= in_col;
            val_reg   <= in_value;
            ha_reg    <= hsa_pkg::HASH_INIT + in_row;
            hb_reg    <= hsa_pkg::HASH_INIT + in_col;
            hc_reg    <= hsa_pkg::HASH_INIT + hsa_pkg::HASH_SEED2;
            round_reg <= 3'd0;
        end else if (cmd.hash_step) begin
            ha_reg    <= ha_next;
            hb_reg    <= hb_next;
            hc_reg    <= hc_next;
            round_reg <= round_reg + 3'd1;
        end
    end

    // Slot memory: {value, col, row}
    assign wr_data = cmd.wr_acc ? {rd_data[95:64] + val_reg, col_reg, row_reg}
                                : {val_reg, col_reg, row_reg};
    hsa_ram #(.WIDTH(hsa_pkg::ENTRY_W), .DEPTH(hsa_pkg::SLOTS)) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn || valid_clear) begin
            valid_reg <= '0;
        end else if (valid_set) begin
            valid_reg[valid_addr] <= 1'b1;
        end
    end
    assign valid_bits = valid_reg;

    // Victim search over the ways read so far
    assign rmag = hsa_pkg::mag(rd_data[95:64]);
    always_ff @(posedge aclk) begin
        if (cmd.track) begin
            if (cmd.track_first || rmag < vmag_reg) begin
                vmag_reg <= rmag;
                vway_reg <= cmd.track_first ? '0 : tway_reg;
            end
            if (cmd.track_first) begin
                tway_reg <= hsa_pkg::WAY_BITS'(1);
            end else begin
                tway_reg <= tway_reg + 1'b1;
            end
        end
        if (cmd.victim_save) begin
            victim_reg <= rd_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (cmd.out_load) begin
            full_reg <= 1'b1;
        end else if (out_take) begin
            full_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_kind <= cmd.out_kind;
            o_last <= cmd.out_last;
            if (cmd.out_kind == hsa_pkg::KIND_END) begin
                {o_value, o_col, o_row} <= '0;
            end else if (cmd.out_victim) begin
                {o_value, o_col, o_row} <= victim_reg;
            end else begin
                {o_value, o_col, o_row} <= rd_data;
            end
        end
    end

    assign sts.bucket     = hb_reg[hsa_pkg::BUCKET_BITS-1:0];
    assign sts.hit        = (rd_data[31:0] == row_reg) && (rd_data[63:32] == col_reg);
    assign sts.victim_way = vway_reg;
    assign sts.out_full   = full_reg;
endmodule
`default_nettype wire

>>> rtl/hsa_ctrl.sv
// Controller: sequences hashing, way probing, eviction and flush sweeps.
`default_nettype none
module hsa_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_req,
    input  wire logic             in_flush,
    output logic                  in_ready,
    input  wire hsa_pkg::hsa_sts_t sts,
    input  wire logic [hsa_pkg::SLOTS-1:0] valid_bits,
    input  wire logic             out_take,
    output hsa_pkg::hsa_cmd_t     cmd,
    output logic                  valid_set,
    output logic [hsa_pkg::SLOT_BITS-1:0] valid_addr,
    output logic                  valid_clear
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_VREAD = 4'd4;
    localparam logic [3:0] S_EVICT = 4'd5;
    localparam logic [3:0] S_FREAD = 4'd6;
    localparam logic [3:0] S_FEMIT = 4'd7;
    localparam logic [3:0] S_END   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [hsa_pkg::WCNT_BITS-1:0] way_reg, way_next;
    logic [hsa_pkg::SCNT_BITS-1:0] slot_reg, slot_next;
    logic [hsa_pkg::SLOT_BITS-1:0] probe_addr, victim_addr, slot_addr;
    logic [hsa_pkg::WAY_BITS-1:0]  way_idx;
    logic out_free;

    assign way_idx     = way_reg[hsa_pkg::WAY_BITS-1:0];
    assign probe_addr  = hsa_pkg::SLOT_BITS'({way_idx, sts.bucket});
    assign victim_addr = hsa_pkg::SLOT_BITS'({sts.victim_way, sts.bucket});
    assign slot_addr   = slot_reg[hsa_pkg::SLOT_BITS-1:0];
    assign out_free    = !sts.out_full || out_take;
    assign in_ready    = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            way_reg   <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            way_reg   <= way_next;
            slot_reg  <= slot_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        way_next    = way_reg;
        slot_next   = slot_reg;
        cmd         = '0;
        valid_set   = 1'b0;
        valid_addr  = probe_addr;
        valid_clear = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_req) begin
                    cmd.load_item = 1'b1;
                    cnt_next  = '0;
                    way_next  = '0;
                    slot_next = '0;
                    state_next = in_flush ? S_FREAD : S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                // free way takes the item at once; otherwise read it
                if (!valid_bits[probe_addr]) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = probe_addr;
                    valid_set   = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = probe_addr;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.hit) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_acc  = 1'b1;
                    cmd.wr_addr = probe_addr;
                    state_next  = S_IDLE;
                end else begin
                    cmd.track       = 1'b1;
                    cmd.track_first = (way_reg == '0);
                    way_next = way_reg + 1'b1;
                    state_next = (way_reg == hsa_pkg::WCNT_BITS'(hsa_pkg::WAYS - 1))
                                 ? S_VREAD : S_PROBE;
                end
            end
            S_VREAD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = victim_addr;
                state_next  = S_EVICT;
            end
            S_EVICT: begin
                if (out_free) begin
                    cmd.victim_save = 1'b1;
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = hsa_pkg::KIND_EVICT;
                    cmd.out_last    = 1'b1;
                    cmd.wr_en       = 1'b1;
                    cmd.wr_addr     = victim_addr;
                    state_next      = S_IDLE;
                end
            end
            S_FREAD: begin
                // sweep slots in way-major order; slot index is {way, bucket}
                if (slot_reg == hsa_pkg::SCNT_BITS'(hsa_pkg::SLOTS)) begin
                    state_next = S_END;
                end else if (valid_bits[slot_addr]) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = slot_addr;
                    state_next  = S_FEMIT;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_FEMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = hsa_pkg::KIND_FLUSH;
                    slot_next    = slot_reg + 1'b1;
                    state_next   = S_FREAD;
                end
            end
            S_END: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = hsa_pkg::KIND_END;
                    cmd.out_last = 1'b1;
                    valid_clear  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/hashed_sketch_accumulator.sv
// Hashed sketch accumulator: set-associative (row, col) summing table.
// Insert: accept, 6 hash rounds, then ways in turn: a free way takes the item, a key
// match sums the values; if all miss, the way of least magnitude is evicted.
// Flush: every valid slot is emitted in slot order, then the end marker.
// The output register lets the next item be taken while a result waits.
// aresetn (synchronous, active low) clears control state and all slot valid bits.
`default_nettype none
module hashed_sketch_accumulator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,  // row_index[31:0], col_index[63:32], value[95:64]
    input  wire logic        s_tuser,  // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,  // out_row[31:0], out_col[63:32], out_value[95:64]
    output logic [1:0]       m_tuser,  // kind
    output logic             m_tlast   // last
);
    hsa_pkg::hsa_cmd_t cmd;
    hsa_pkg::hsa_sts_t sts;
    logic [hsa_pkg::SLOTS-1:0] valid_bits;
    logic valid_set, valid_clear;
    logic [hsa_pkg::SLOT_BITS-1:0] valid_addr;
    logic out_take;
    logic [31:0] o_row, o_col, o_value;

    assign out_take = m_tvalid && m_tready;

    hsa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_req      (s_tvalid),
        .in_flush    (s_tuser),
        .in_ready    (s_tready),
        .sts         (sts),
        .valid_bits  (valid_bits),
        .out_take    (out_take),
        .cmd         (cmd),
        .valid_set   (valid_set),
        .valid_addr  (valid_addr),
        .valid_clear (valid_clear)
    );

    hsa_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_row      (s_tdata[31:0]),
        .in_col      (s_tdata[63:32]),
        .in_value    (s_tdata[95:64]),
        .cmd         (cmd),
        .valid_set   (valid_set),
        .valid_addr  (valid_addr),
        .valid_clear (valid_clear),
        .valid_bits  (valid_bits),
        .sts         (sts),
        .out_take    (out_take),
        .o_kind      (m_tuser),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_value     (o_value),
        .o_last      (m_tlast)
    );

    assign m_tvalid = sts.out_full;
    assign m_tdata  = {o_value, o_col, o_row};

    // An end marker always carries last and a zero payload
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == hsa_pkg::KIND_END) |-> (m_tlast && m_tdata == '0))
        else $error("end marker without last or with payload");
    // A flushed entry never carries last
    a_flush_nolast: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == hsa_pkg::KIND_FLUSH) |-> !m_tlast)
        else $error("flushed entry marked last");
    // The table is empty after an end marker is loaded
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_clear |=> (valid_bits == '0))
        else $error("table not cleared by flush");
endmodule
`default_nettype wire
